@@ rtl/xrr_pkg.sv @@
package xrr_pkg;

  localparam int unsigned FieldW = 31;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CntW   = $clog2(WordW);

  localparam logic [WordW-1:0] SeedX = 32'd123456789;
  localparam logic [WordW-1:0] SeedY = 32'd362436069;
  localparam logic [WordW-1:0] SeedZ = 32'd521288629;
  localparam logic [WordW-1:0] SeedW = 32'd88675123;

  localparam int unsigned ShiftA = 11;
  localparam int unsigned ShiftB = 19;
  localparam int unsigned ShiftC = 8;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [WordW-1:0]  word_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } xrr_state_e;

endpackage

@@ rtl/xrr_in_if.sv @@
interface xrr_in_if;
  import xrr_pkg::*;

  logic   valid;
  logic   ready;
  field_t lo;
  field_t hi;

  modport source (output valid, output lo, output hi, input ready);
  modport sink   (input valid, input lo, input hi, output ready);
endinterface

@@ rtl/xrr_out_if.sv @@
interface xrr_out_if;
  import xrr_pkg::*;

  logic   valid;
  logic   ready;
  field_t value;
  logic   range_error;

  modport source (output valid, output value, output range_error, input ready);
  modport sink   (input valid, input value, input range_error, output ready);
endinterface

@@ rtl/xorshift_range_random_unit.sv @@
// xorshift_range_random_unit: bounded random draw from a 128-bit xorshift
// generator.
// in_i (sink): one beat carries lo and hi, the inclusive bounds. Each beat
// advances the generator one step and yields exactly one beat on out_o
// (source) with value = lo + (word mod (hi - lo + 1)) and range_error = 0.
// When hi is below lo the generator still advances, value is 0 and
// range_error is 1.
// Steps: the generator steps on the accepting edge, the LOAD state starts the
// remainder unit, the 32-step bit-serial remainder runs, and the output
// register takes lo plus the remainder; an error beat skips the remainder.
// A new beat is taken only once the last has moved into the output register.
// in_i.ready is high while no beat is in flight. A finished beat sits in the
// output register; the next input beat is taken while it waits, and that
// beat holds in its last step until the output register is free.
// Reset loads the four generator words with their fixed seeds and empties
// the output register.
module xorshift_range_random_unit (
  input  logic clk_i,
  input  logic rst_ni,
  xrr_in_if.sink    in_i,
  xrr_out_if.source out_o
);
  import xrr_pkg::*;

  xrr_state_e state_q, state_d;
  field_t     lo_q;
  word_t      span_q;
  logic       err_q;
  logic       out_valid_q, out_valid_d;
  field_t     value_q;
  logic       range_error_q;

  logic       in_fire;
  logic       out_load;
  logic       div_start;
  logic       div_done;
  field_t     rem;
  word_t      word;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  assign div_start  = (state_q == ST_LOAD) && !err_q;

  xrr_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_fire),
    .word_o    (word)
  );

  xrr_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (word),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = err_q ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lo_q   <= in_i.lo;
      err_q  <= (in_i.hi < in_i.lo);
      span_q <= {1'b0, in_i.hi} - {1'b0, in_i.lo} + WordW'(1);
    end
    if (out_load) begin
      value_q       <= err_q ? '0 : (lo_q + rem);
      range_error_q <= err_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = value_q;
  assign out_o.range_error = range_error_q;
endmodule

@@ rtl/xrr_gen.sv @@
module xrr_gen (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  output xrr_pkg::word_t word_o
);
  import xrr_pkg::*;

  word_t x_q, y_q, z_q, w_q;
  word_t t;
  word_t w_d;

  assign t   = x_q ^ (x_q << ShiftA);
  assign w_d = w_q ^ (w_q >> ShiftB) ^ t ^ (t >> ShiftC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= SeedX;
      y_q <= SeedY;
      z_q <= SeedZ;
      w_q <= SeedW;
    end else if (advance_i) begin
      x_q <= y_q;
      y_q <= z_q;
      z_q <= w_q;
      w_q <= w_d;
    end
  end

  assign word_o = w_q;
endmodule

@@ rtl/xrr_mod.sv @@
module xrr_mod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  xrr_pkg::word_t dividend_i,
  input  xrr_pkg::word_t divisor_i,
  output logic           done_o,
  output xrr_pkg::field_t rem_o
);
  import xrr_pkg::*;

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  word_t             shift_q;
  word_t             divisor_q;
  field_t            rem_q;
  field_t            rem_d;
  word_t             trial;
  logic [WordW:0]    diff;

  // one quotient bit per cycle, dividend shifted in msb first
  assign trial = {rem_q, shift_q[WordW-1]};
  assign diff  = {1'b0, trial} - {1'b0, divisor_q};
  assign rem_d = diff[WordW] ? trial[FieldW-1:0] : diff[FieldW-1:0];

  assign done_o = busy_q && (cnt_q == CntW'(WordW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q   <= dividend_i;
      divisor_q <= divisor_i;
      rem_q     <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[WordW-2:0], 1'b0};
      rem_q   <= rem_d;
    end
  end

  assign rem_o = rem_q;
endmodule

@@ rtl/xrr_checker.sv @@
module xrr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input xrr_pkg::field_t out_value_i,
  input logic            out_range_error_i
);
  import xrr_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
      && $stable(out_range_error_i))
    else $error("output beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_range_error_i |-> out_value_i == '0)
    else $error("error beat with nonzero value");

  // one beat in flight at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result shown while still busy");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared right after accept");
endmodule

bind xorshift_range_random_unit xrr_checker u_xrr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_value_i       (out_o.value),
  .out_range_error_i (out_o.range_error)
);

@@ tb/xorshift_range_random_unit_test.sv @@
module xorshift_range_random_unit_test;
  import xrr_pkg::*;

  typedef enum int unsigned {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  typedef struct {
    field_t      lo;
    field_t      hi;
    idle_phase_e phase;
    bit          drain;
  } bounds_t;

  typedef struct {
    field_t value;
    logic   range_error;
  } draw_t;

  localparam field_t FieldMax = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  xrr_in_if  in_bus ();
  xrr_out_if out_bus ();

  xorshift_range_random_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  bounds_t     bounds_q[$];
  draw_t       draw_q[$];
  idle_phase_e phase_now;
  int unsigned mismatch_count = 0;

  word_t gen_x = SeedX;
  word_t gen_y = SeedY;
  word_t gen_z = SeedZ;
  word_t gen_w = SeedW;

  // one generator step, then the bounded draw
  function automatic draw_t draw_in_range(field_t lo, field_t hi);
    word_t t;
    word_t span;
    draw_t r;
    t     = gen_x ^ (gen_x << ShiftA);
    gen_x = gen_y;
    gen_y = gen_z;
    gen_z = gen_w;
    gen_w = gen_w ^ (gen_w >> ShiftB) ^ t ^ (t >> ShiftC);
    if (hi < lo) begin
      r.value       = '0;
      r.range_error = 1'b1;
    end else begin
      span          = word_t'(hi) - word_t'(lo) + 32'd1;
      r.value       = field_t'(word_t'(lo) + (gen_w % span));
      r.range_error = 1'b0;
    end
    return r;
  endfunction

  task automatic add_bounds(field_t lo, field_t hi, idle_phase_e phase, bit drain);
    bounds_t b;
    b.lo    = lo;
    b.hi    = hi;
    b.phase = phase;
    b.drain = drain;
    bounds_q = {bounds_q, b};
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned idle_pct;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.lo    <= '0;
      in_bus.hi    <= '0;
      phase_now    <= PH_FREE;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        draw_q = {draw_q, draw_in_range(in_bus.lo, in_bus.hi)};
      end
      if (!in_bus.valid || in_bus.ready) begin
        idle_pct = 0;
        if (bounds_q.size() != 0) begin
          idle_pct = (bounds_q[0].phase == PH_SEND_IDLE) ? 68 :
                     (bounds_q[0].phase == PH_BOTH) ? 17 : 0;
        end
        if (bounds_q.size() != 0 && !(bounds_q[0].drain && draw_q.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          in_bus.lo    <= bounds_q[0].lo;
          in_bus.hi    <= bounds_q[0].hi;
          phase_now    <= bounds_q[0].phase;
          in_bus.valid <= 1'b1;
          void'(bounds_q.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall_pct;
    draw_t exp_d;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (draw_q.size() == 0) begin
          $error("result beat with no expectation: value=%0d range_error=%0b",
                 out_bus.value, out_bus.range_error);
          mismatch_count++;
        end else begin
          exp_d = draw_q.pop_front();
          if (out_bus.value !== exp_d.value) begin
            $error("value: expected %0d, got %0d", exp_d.value, out_bus.value);
            mismatch_count++;
          end
          if (out_bus.range_error !== exp_d.range_error) begin
            $error("range_error: expected %0b, got %0b",
                   exp_d.range_error, out_bus.range_error);
            mismatch_count++;
          end
        end
      end
      stall_pct = (phase_now == PH_RECV_STALL) ? 68 : (phase_now == PH_BOTH) ? 17 : 0;
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    field_t lo;
    field_t hi;
    field_t tmp;
    idle_phase_e phase;
    int unsigned kind;

    rst_ni = 1'b0;

    // directed: extremes, full span, equal and inverted bounds
    add_bounds('0, FieldMax, PH_FREE, 1'b0);
    add_bounds('0, '0, PH_FREE, 1'b0);
    add_bounds(FieldMax, FieldMax, PH_FREE, 1'b0);
    add_bounds(FieldMax, '0, PH_FREE, 1'b0);
    add_bounds(field_t'(1), '0, PH_FREE, 1'b0);
    add_bounds('0, field_t'(1), PH_FREE, 1'b0);
    add_bounds(FieldMax - field_t'(1), FieldMax, PH_FREE, 1'b0);
    add_bounds(field_t'(5), field_t'(4), PH_FREE, 1'b0);
    add_bounds(field_t'(31'h4000_0000), field_t'(31'h3fff_ffff), PH_FREE, 1'b0);
    add_bounds('0, field_t'(31'h3fff_ffff), PH_FREE, 1'b0);
    add_bounds(field_t'(31'h5555_5555), FieldMax, PH_FREE, 1'b0);
    add_bounds(field_t'(31'h2aaa_aaaa), field_t'(31'h5555_5555), PH_FREE, 1'b0);
    add_bounds(field_t'(123), field_t'(123), PH_FREE, 1'b0);
    add_bounds(field_t'(1), FieldMax, PH_FREE, 1'b0);
    add_bounds('0, FieldMax - field_t'(1), PH_FREE, 1'b0);
    add_bounds(field_t'(1000), field_t'(1255), PH_FREE, 1'b0);
    add_bounds(field_t'(7), field_t'(8), PH_FREE, 1'b0);
    add_bounds(FieldMax, FieldMax - field_t'(1), PH_FREE, 1'b0);
    add_bounds(field_t'(31'h3fff_ffff), field_t'(31'h4000_0000), PH_FREE, 1'b0);
    add_bounds('0, field_t'(31'h0000_ffff), PH_FREE, 1'b0);

    for (int i = 0; i < 1450; i++) begin
      phase = idle_phase_e'((i / 90) % 4);
      kind  = $urandom_range(99);
      lo    = field_t'($urandom());
      hi    = field_t'($urandom());
      if (kind < 20) begin
        // inverted bounds
        if (lo == hi) begin
          if (lo == '0) lo = field_t'(1);
          hi = lo - field_t'(1);
        end else if (hi > lo) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end else if (kind < 30) begin
        hi = lo;
      end else if (kind < 40) begin
        lo = field_t'($urandom_range(3));
        hi = FieldMax - field_t'($urandom_range(3));
      end else if (kind < 70) begin
        lo = field_t'($urandom_range(32'h7fff_feff));
        hi = lo + field_t'($urandom_range(255));
      end else if (hi < lo) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      add_bounds(lo, hi, phase, (i % 300) == 150);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bounds_q.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (draw_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
